[rtl/core/ttd_pkg.sv]
// Package for the travel time block: pipeline payload types and constants.
// Used by every module under rtl/core; depends on nothing.
package ttd_pkg;

    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_IDX_W = 4;

    localparam logic [31:0] SQRT_TOP_DIGIT = 32'h4000_0000;
    localparam logic [6:0]  HUNDRED        = 7'd100;
    localparam logic [15:0] DURATION_MAX   = 16'hFFFF;
    localparam logic [15:0] DURATION_MIN   = 16'd1;
    localparam logic [9:0]  TPS_RESET      = 10'd60;

    // Payload that travels down the square root chain.
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] root;
        logic [15:0] speed;
    } sqrt_data_t;

    // Payload that travels down the divider chain.
    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] low;
        logic [15:0] quot;
        logic [15:0] speed;
        logic        force_one;
        logic        force_max;
    } div_data_t;

endpackage

[rtl/core/ttd_front.sv]
// Front end: coordinate differences, then the squared distance wrapped to 32 bits.
// Depends on ttd_pkg.
module ttd_front
    import ttd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] goal_x,
    input  logic signed [15:0] goal_y,
    input  logic [15:0]       speed,
    output logic              out_valid,
    output sqrt_data_t        out_data
);

    logic               diff_valid_reg;
    logic signed [16:0] dx_reg;
    logic signed [16:0] dy_reg;
    logic [15:0]        diff_speed_reg;
    logic               sq_valid_reg;
    sqrt_data_t         sq_data_reg;
    logic [33:0]        dx_sq;
    logic [33:0]        dy_sq;
    logic [31:0]        dist_sq;

    always_comb begin
        dx_sq   = 34'(dx_reg * dx_reg);
        dy_sq   = 34'(dy_reg * dy_reg);
        dist_sq = 32'(dx_sq + dy_sq);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_valid_reg <= 1'b0;
            sq_valid_reg   <= 1'b0;
        end else if (en) begin
            diff_valid_reg <= in_valid;
            sq_valid_reg   <= diff_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg            <= 17'(start_x) - 17'(goal_x);
            dy_reg            <= 17'(start_y) - 17'(goal_y);
            diff_speed_reg    <= speed;
            sq_data_reg.rem   <= dist_sq;
            sq_data_reg.root  <= '0;
            sq_data_reg.speed <= diff_speed_reg;
        end
    end

    assign out_valid = sq_valid_reg;
    assign out_data  = sq_data_reg;

endmodule

[rtl/core/ttd_sqrt_cell.sv]
// One base-four digit step of the floor square root.
// Depends on ttd_pkg; the step index selects the digit this cell tries.
module ttd_sqrt_cell
    import ttd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [STEP_IDX_W-1:0] step_idx,
    input  logic                  in_valid,
    input  sqrt_data_t            in_data,
    output logic                  out_valid,
    output sqrt_data_t            out_data
);

    logic        valid_reg;
    sqrt_data_t  data_reg;
    sqrt_data_t  data_next;
    logic [31:0] digit;
    logic [32:0] trial;

    always_comb begin
        digit     = SQRT_TOP_DIGIT >> {step_idx, 1'b0};
        trial     = {1'b0, in_data.root} + {1'b0, digit};
        data_next = in_data;
        if ({1'b0, in_data.rem} >= trial) begin
            data_next.rem  = in_data.rem - trial[31:0];
            data_next.root = (in_data.root >> 1) + digit;
        end else begin
            data_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/core/ttd_scale.sv]
// Scaling stages: distance times tick rate, then times one hundred plus the
// rounding term, and the saturation test. Depends on ttd_pkg.
module ttd_scale
    import ttd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [9:0]  ticks_per_second,
    input  logic        in_valid,
    input  sqrt_data_t  in_data,
    output logic        out_valid,
    output div_data_t   out_data
);

    logic        mul_valid_reg;
    logic [25:0] prod_reg;
    logic [15:0] mul_speed_reg;
    logic        mul_force_one_reg;
    logic        num_valid_reg;
    div_data_t   num_data_reg;
    logic [15:0] dist_root;
    logic [33:0] num_adj;
    logic        too_big;

    assign dist_root = in_data.root[15:0];

    always_comb begin
        // The rounded-up quotient is floor((num + speed - 1) / speed).
        num_adj = 34'(prod_reg * HUNDRED) + 34'(mul_speed_reg) - 34'd1;
        too_big = num_adj[33:16] >= {2'b00, mul_speed_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            num_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= in_valid;
            num_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg               <= 26'(dist_root * ticks_per_second);
            mul_speed_reg          <= in_data.speed;
            mul_force_one_reg      <= (dist_root == '0) || (in_data.speed == '0);
            num_data_reg.rem       <= num_adj[31:16];
            num_data_reg.low       <= num_adj[15:0];
            num_data_reg.quot      <= '0;
            num_data_reg.speed     <= mul_speed_reg;
            num_data_reg.force_one <= mul_force_one_reg;
            num_data_reg.force_max <= too_big;
        end
    end

    assign out_valid = num_valid_reg;
    assign out_data  = num_data_reg;

endmodule

[rtl/core/ttd_div_cell.sv]
// One restoring division step: brings down one bit and yields one quotient bit.
// Depends on ttd_pkg.
module ttd_div_cell
    import ttd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  div_data_t in_data,
    output logic      out_valid,
    output div_data_t out_data
);

    logic        valid_reg;
    div_data_t   data_reg;
    div_data_t   data_next;
    logic [16:0] trial;
    logic        fits;

    always_comb begin
        trial          = {in_data.rem, in_data.low[15]};
        fits           = trial >= {1'b0, in_data.speed};
        data_next      = in_data;
        data_next.low  = {in_data.low[14:0], 1'b0};
        data_next.quot = {in_data.quot[14:0], fits};
        data_next.rem  = fits ? 16'(trial - {1'b0, in_data.speed}) : trial[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/core/travel_time_from_distance_top.sv]
// Top level of the travel time block: tick rate register, pipeline of cells
// and output register. Depends on ttd_pkg and all ttd_* modules.
//
// Each item runs from acceptance to result through two front-end stages
// (difference, square), sixteen square root digit cells, two scaling stages,
// sixteen divider cells and the output register. The pipeline takes a new item
// in every cycle; all stages advance together whenever the output register is
// empty or its item is being taken, so a stall on the result side holds the
// whole chain. The tick rate register is written through the cfg_ channel and
// should only change while no item is in flight.
module travel_time_from_distance_top
    import ttd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_ticks_per_second,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_start_x,
    input  logic signed [15:0] s_start_y,
    input  logic signed [15:0] s_goal_x,
    input  logic signed [15:0] s_goal_y,
    input  logic [15:0] s_speed_hundredths,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_duration_ticks
);

    logic        en;
    logic [9:0]  tps_reg;
    logic        out_valid_reg;
    logic [15:0] duration_reg;
    logic [15:0] duration_next;

    logic        sqrt_valid [0:SQRT_STEPS];
    sqrt_data_t  sqrt_data  [0:SQRT_STEPS];
    logic        div_valid  [0:DIV_STEPS];
    div_data_t   div_data   [0:DIV_STEPS];

    assign en        = !out_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg <= TPS_RESET;
        end else if (cfg_valid) begin
            tps_reg <= cfg_ticks_per_second;
        end
    end

    ttd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .start_x   (s_start_x),
        .start_y   (s_start_y),
        .goal_x    (s_goal_x),
        .goal_y    (s_goal_y),
        .speed     (s_speed_hundredths),
        .out_valid (sqrt_valid[0]),
        .out_data  (sqrt_data[0])
    );

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        ttd_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .step_idx  (STEP_IDX_W'(i)),
            .in_valid  (sqrt_valid[i]),
            .in_data   (sqrt_data[i]),
            .out_valid (sqrt_valid[i+1]),
            .out_data  (sqrt_data[i+1])
        );
    end

    ttd_scale u_scale (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en),
        .ticks_per_second (tps_reg),
        .in_valid         (sqrt_valid[SQRT_STEPS]),
        .in_data          (sqrt_data[SQRT_STEPS]),
        .out_valid        (div_valid[0]),
        .out_data         (div_data[0])
    );

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        ttd_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (div_valid[j]),
            .in_data   (div_data[j]),
            .out_valid (div_valid[j+1]),
            .out_data  (div_data[j+1])
        );
    end

    always_comb begin
        if (div_data[DIV_STEPS].force_one) begin
            duration_next = DURATION_MIN;
        end else if (div_data[DIV_STEPS].force_max) begin
            duration_next = DURATION_MAX;
        end else if (div_data[DIV_STEPS].quot == '0) begin
            // A zero tick rate gives a zero quotient, which clamps to one.
            duration_next = DURATION_MIN;
        end else begin
            duration_next = div_data[DIV_STEPS].quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= div_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            duration_reg <= duration_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_duration_ticks = duration_reg;

endmodule
